// File: rtl/core/fbtd_pkg.sv
// ============================================================================
// fbtd_pkg
// Shared types, constants and the character ROM of the five-bit packed text
// decoder.
// ============================================================================
package fbtd_pkg;

    // Special 5-bit codes.
    localparam logic [4:0] C_CODE_END  = 5'h00;
    localparam logic [4:0] C_CODE_CASE = 5'h1E;
    localparam logic [4:0] C_CODE_NULL = 5'h1F;

    // Case handling constants.
    localparam logic [7:0] C_CASE_LIMIT = 8'h40;
    localparam logic [7:0] C_CASE_ARM   = 8'h80;
    localparam logic [7:0] C_UPPER_MIN  = 8'hE1;
    localparam logic [7:0] C_UPPER_MAX  = 8'hFA;
    localparam logic [7:0] C_UPPER_MASK = 8'hDF;

    // Depth of the queue between front and back.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // What a decoded code asks the back part to do.
    typedef enum logic [1:0] {
        K_END,
        K_CHAR,
        K_CASE
    } t_code_kind;

    // One input byte, decoded into up to two codes.
    typedef struct packed {
        logic       vld0;
        t_code_kind kind0;
        logic [4:0] code0;
        logic       last0;
        logic       vld1;
        t_code_kind kind1;
        logic [4:0] code1;
        logic       last1;
    } t_code_grp;

    // Character ROM for codes 1 to 29.
    function automatic logic [7:0] f_char_rom(input logic [4:0] code);
        logic [7:0] ch;
        unique case (code)
            5'd1:    ch = 8'hA0;
            5'd2:    ch = 8'hE1;
            5'd3:    ch = 8'hE2;
            5'd4:    ch = 8'hE3;
            5'd5:    ch = 8'hE4;
            5'd6:    ch = 8'hE5;
            5'd7:    ch = 8'hE6;
            5'd8:    ch = 8'hE7;
            5'd9:    ch = 8'hE8;
            5'd10:   ch = 8'hE9;
            5'd11:   ch = 8'hEB;
            5'd12:   ch = 8'hEC;
            5'd13:   ch = 8'hED;
            5'd14:   ch = 8'hEE;
            5'd15:   ch = 8'hEF;
            5'd16:   ch = 8'hF0;
            5'd17:   ch = 8'hF2;
            5'd18:   ch = 8'hF3;
            5'd19:   ch = 8'hF4;
            5'd20:   ch = 8'hF5;
            5'd21:   ch = 8'hF6;
            5'd22:   ch = 8'hF7;
            5'd23:   ch = 8'hF9;
            5'd24:   ch = 8'hAE;
            5'd25:   ch = 8'hA2;
            5'd26:   ch = 8'hA7;
            5'd27:   ch = 8'hAC;
            5'd28:   ch = 8'hA1;
            5'd29:   ch = 8'h8D;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// File: rtl/core/fbtd_front.sv
// ============================================================================
// fbtd_front
// Accepts packed bytes, gathers bits into 5-bit codes and classifies them
// into a code group for the back part.
// ============================================================================
module fbtd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_packed_byte,
    input  logic                i_q_full,
    output logic                o_push,
    output fbtd_pkg::t_code_grp o_grp
);
    import fbtd_pkg::*;

    logic [4:0]  r_accum;
    logic [2:0]  r_cnt;
    logic [4:0]  n_accum;
    logic [2:0]  n_cnt;
    logic [12:0] w_bits;
    logic        w_two;
    logic [4:0]  w_code0;
    logic [4:0]  w_code1;
    logic [2:0]  w_left_cnt;
    logic        w_res0;
    logic        w_res1;
    logic        w_end;
    logic        w_accept;
    t_code_grp   w_grp;

    function automatic t_code_kind f_kind(input logic [4:0] code);
        t_code_kind k;
        if (code == C_CODE_END) begin
            k = K_END;
        end else if (code == C_CODE_CASE) begin
            k = K_CASE;
        end else begin
            k = K_CHAR;
        end
        return k;
    endfunction

    assign w_accept = i_valid && !i_q_full;

    // Split the gathered bits and the new byte into codes.
    always_comb begin
        w_bits  = {r_accum, i_packed_byte};
        w_two   = (r_cnt >= 3'd2);
        w_code0 = 5'(w_bits >> (r_cnt + 3'd3));
        w_code1 = 5'(w_bits >> (r_cnt - 3'd2));
        if (w_two) begin
            w_left_cnt = r_cnt - 3'd2;
        end else begin
            w_left_cnt = r_cnt + 3'd3;
        end

        // An end code in the first slot discards the rest of the byte.
        w_grp.vld0  = (w_code0 != C_CODE_NULL);
        w_grp.kind0 = f_kind(w_code0);
        w_grp.code0 = w_code0;
        w_grp.vld1  = w_two && (w_code0 != C_CODE_END) && (w_code1 != C_CODE_NULL);
        w_grp.kind1 = f_kind(w_code1);
        w_grp.code1 = w_code1;

        w_res0 = w_grp.vld0 && (w_grp.kind0 != K_CASE);
        w_res1 = w_grp.vld1 && (w_grp.kind1 != K_CASE);
        w_grp.last0 = w_res0 && !w_res1;
        w_grp.last1 = w_res1;

        w_end = (w_code0 == C_CODE_END) || (w_two && w_code1 == C_CODE_END);
        if (w_end) begin
            n_accum = 5'd0;
            n_cnt   = 3'd0;
        end else begin
            n_accum = w_bits[4:0] & ~(5'h1F << w_left_cnt);
            n_cnt   = w_left_cnt;
        end
    end

    // Bit gathering state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum <= 5'd0;
            r_cnt   <= 3'd0;
        end else if (w_accept) begin
            r_accum <= n_accum;
            r_cnt   <= n_cnt;
        end
    end

    assign o_push = w_accept && (w_grp.vld0 || w_grp.vld1);
    assign o_grp  = w_grp;

endmodule

// File: rtl/core/fbtd_queue.sv
// ============================================================================
// fbtd_queue
// Short FIFO of code groups between the front and back parts.
// ============================================================================
module fbtd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  fbtd_pkg::t_code_grp i_grp,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_empty,
    output fbtd_pkg::t_code_grp o_grp
);
    import fbtd_pkg::*;

    t_code_grp          r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_grp   = r_mem[r_rd_ptr];

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_grp;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/fbtd_back.sv
// ============================================================================
// fbtd_back
// Carries out queued codes one per cycle unless stalled: case register
// updates, ROM lookup with upper-case folding, and the output register.
// ============================================================================
module fbtd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  fbtd_pkg::t_code_grp i_grp,
    output logic                o_pop,
    input  logic                i_stall,
    output logic                o_valid,
    output logic [7:0]          o_char_code,
    output logic                o_end_of_string,
    output logic                o_last_of_item
);
    import fbtd_pkg::*;

    logic       r_sel;
    logic [7:0] r_case;
    logic       r_out_vld;
    logic [7:0] r_out_char;
    logic       r_out_eos;
    logic       r_out_last;

    logic       w_slot1;
    logic [4:0] w_code;
    t_code_kind w_kind;
    logic       w_last;
    logic       w_grp_done;
    logic       w_can_out;
    logic       w_fire;
    logic [7:0] w_case_shr;
    logic [7:0] w_rom;
    logic [7:0] n_case;
    logic [7:0] n_char;

    // Select the code in work from the head group.
    always_comb begin
        w_slot1    = r_sel || !i_grp.vld0;
        w_code     = w_slot1 ? i_grp.code1 : i_grp.code0;
        w_kind     = w_slot1 ? i_grp.kind1 : i_grp.kind0;
        w_last     = w_slot1 ? i_grp.last1 : i_grp.last0;
        w_grp_done = w_slot1 || !i_grp.vld1;
        w_can_out  = !r_out_vld || !i_stall;
        w_fire     = !i_q_empty && ((w_kind == K_CASE) || w_can_out);
    end

    // Case register update and character folding.
    always_comb begin
        w_case_shr = r_case >> 1;
        w_rom      = f_char_rom(w_code);
        n_char     = w_rom;
        unique case (w_kind)
            K_END: begin
                n_case = 8'h00;
                n_char = 8'h00;
            end
            K_CASE: begin
                n_case = w_case_shr + C_CASE_ARM;
            end
            K_CHAR: begin
                n_case = w_case_shr;
                if (w_case_shr >= C_CASE_LIMIT && w_rom >= C_UPPER_MIN
                    && w_rom <= C_UPPER_MAX) begin
                    n_char = w_rom & C_UPPER_MASK;
                end
            end
            default: begin
                n_case = r_case;
            end
        endcase
    end

    // Slot select and case register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel  <= 1'b0;
            r_case <= 8'h00;
        end else if (w_fire) begin
            r_sel  <= !w_grp_done;
            r_case <= n_case;
        end
    end

    // Output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_fire && w_kind != K_CASE) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (w_fire && w_kind != K_CASE) begin
            r_out_char <= n_char;
            r_out_eos  <= (w_kind == K_END);
            r_out_last <= w_last;
        end
    end

    assign o_pop           = w_fire && w_grp_done;
    assign o_valid         = r_out_vld;
    assign o_char_code     = r_out_char;
    assign o_end_of_string = r_out_eos;
    assign o_last_of_item  = r_out_last;

endmodule

// File: rtl/core/five_bit_packed_text_decoder.sv
// ============================================================================
// five_bit_packed_text_decoder
// Decodes a stream of bytes that pack 5-bit text codes, MSB first, into
// characters, with end-of-string and case-shift handling.
// ============================================================================
//
//  Channel  | Direction | Handshake           | Payload
//  ---------+-----------+---------------------+----------------------------------
//  input    | in        | i_valid / o_stall   | i_packed_byte
//  output   | out       | o_valid / i_stall   | o_char_code, o_end_of_string,
//           |           |                     | o_last_of_item
//
// The front decodes a byte in the cycle of its transfer and queues its codes.
// The back carries out one code per cycle while the output is not stalled,
// and each result is held in its output register. The single back unit sets
// the rate; the front keeps taking bytes while the queue has room. The queue
// holds four byte groups. Reset is synchronous and clears the control state;
// queue storage and the output payload are not reset.
// o_stall rises only when the queue is full; a stalled output holds its value.
//
module five_bit_packed_text_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_packed_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_char_code,
    output logic       o_end_of_string,
    output logic       o_last_of_item
);
    import fbtd_pkg::*;

    logic      w_push;
    logic      w_pop;
    logic      w_full;
    logic      w_empty;
    t_code_grp w_in_grp;
    t_code_grp w_head_grp;

    // Front: bit gathering and code classification.
    fbtd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_packed_byte (i_packed_byte),
        .i_q_full      (w_full),
        .o_push        (w_push),
        .o_grp         (w_in_grp)
    );

    // Queue of code groups.
    fbtd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_grp   (w_in_grp),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_grp   (w_head_grp)
    );

    // Back: code execution and result register.
    fbtd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (w_empty),
        .i_grp           (w_head_grp),
        .o_pop           (w_pop),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_char_code     (o_char_code),
        .o_end_of_string (o_end_of_string),
        .o_last_of_item  (o_last_of_item)
    );

    assign o_stall = w_full;

endmodule

// File: rtl/core/fbtd_checker.sv
// ============================================================================
// fbtd_checker
// Port-level checks of the five-bit packed text decoder, bound to the top.
// ============================================================================
module fbtd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_char_code,
    input logic       o_end_of_string,
    input logic       o_last_of_item
);

    // Reset leaves no result pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // An end result carries character zero and closes the byte's results.
    a_end_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_end_of_string |-> o_last_of_item && o_char_code == 8'h00)
        else $error("malformed end-of-string result");

    // A character result is never zero.
    a_char_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_end_of_string |-> o_char_code != 8'h00)
        else $error("character result of zero");

    // A stalled result holds until its transfer.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_char_code)
            && $stable(o_end_of_string) && $stable(o_last_of_item))
        else $error("stalled result changed");

endmodule

bind five_bit_packed_text_decoder fbtd_checker u_fbtd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_char_code     (o_char_code),
    .o_end_of_string (o_end_of_string),
    .o_last_of_item  (o_last_of_item)
);

// File: dv/tb_five_bit_packed_text_decoder.sv
// ============================================================================
// tb_five_bit_packed_text_decoder
// Self-checking bench for the five-bit packed text decoder. A short scripted
// stream covers every code except 16, the case shift and end codes in both slots of a
// byte. It is followed by random strings of codes packed into bytes, mixed
// with raw noise bytes. A decoder model predicts the results of untyped rows;
// the output stream is compared against them field by field, with random idle
// gaps on the input side, random output stalls and one long hold-off.
// ============================================================================
module tb_five_bit_packed_text_decoder;

    import fbtd_pkg::*;

    // One output transfer: character, end flag and last-of-byte flag.
    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
        logic       last;
    } t_char_result;

    // One input byte, with a hand-written expectation when typed is set.
    typedef struct packed {
        logic [7:0]   pbyte;
        logic         typed;
        logic [1:0]   n;
        t_char_result r0;
        t_char_result r1;
    } t_stim_row;

    // Character table, code 1 in the lowest byte.
    localparam logic [29*8-1:0] GLYPHS = {
        8'h8D, 8'hA1, 8'hAC, 8'hA7, 8'hA2, 8'hAE, 8'hF9, 8'hF7, 8'hF6, 8'hF5,
        8'hF4, 8'hF3, 8'hF2, 8'hF0, 8'hEF, 8'hEE, 8'hED, 8'hEC, 8'hEB, 8'hE9,
        8'hE8, 8'hE7, 8'hE6, 8'hE5, 8'hE4, 8'hE3, 8'hE2, 8'hE1, 8'hA0
    };

    localparam t_char_result NO_RESULT = '0;
    localparam t_char_result END_LAST  = {8'h00, 1'b1, 1'b1};
    localparam t_char_result A1_FIRST  = {8'hA1, 1'b0, 1'b0};

    localparam int RANDOM_ITEMS = 800;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int LIMIT_CYCLES = 1000000;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_packed_byte;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_char_code;
    logic       o_end_of_string;
    logic       o_last_of_item;

    five_bit_packed_text_decoder i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_packed_byte   (i_packed_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_char_code     (o_char_code),
        .o_end_of_string (o_end_of_string),
        .o_last_of_item  (o_last_of_item)
    );

    // Decoder model state.
    logic [4:0]   dec_accum;
    logic [2:0]   dec_nbits;
    logic [7:0]   dec_case;
    t_char_result fresh_chars [0:1];
    int           fresh_n;

    t_stim_row    stim_q [$];
    logic         pack_bits [$];
    t_char_result pending_chars [$];

    int cycle_count = 0;
    int bytes_accepted;
    int chars_checked = 0;
    int ends_checked = 0;
    int uppers_predicted;
    int mismatches = 0;
    int stall_left = 0;
    bit hold_done = 1'b0;

    // Clock: 20 time units per period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Runs one byte through the decoder model, filling fresh_chars.
    task automatic decode_byte(input logic [7:0] b);
        logic [4:0]   code;
        logic [7:0]   ch;
        t_char_result r;
        fresh_n = 0;
        for (int i = 7; i >= 0; i--) begin
            dec_accum = {dec_accum[3:0], b[i]};
            dec_nbits = dec_nbits + 3'd1;
            if (dec_nbits == 3'd5) begin
                code = dec_accum;
                dec_accum = '0;
                dec_nbits = '0;
                if (code == C_CODE_END) begin
                    // The end code drops the rest of the byte and clears all state.
                    r.ch = 8'h00;
                    r.eos = 1'b1;
                    r.last = 1'b0;
                    fresh_chars[fresh_n] = r;
                    fresh_n++;
                    dec_case = '0;
                    break;
                end else if (code == C_CODE_CASE) begin
                    dec_case = (dec_case >> 1) + C_CASE_ARM;
                end else if (code != C_CODE_NULL) begin
                    ch = GLYPHS[(int'(code) - 1) * 8 +: 8];
                    dec_case = dec_case >> 1;
                    if (dec_case >= C_CASE_LIMIT && ch >= C_UPPER_MIN && ch <= C_UPPER_MAX) begin
                        ch = ch & C_UPPER_MASK;
                        uppers_predicted++;
                    end
                    r.ch = ch;
                    r.eos = 1'b0;
                    r.last = 1'b0;
                    fresh_chars[fresh_n] = r;
                    fresh_n++;
                end
            end
        end
        if (fresh_n > 0)
            fresh_chars[fresh_n - 1].last = 1'b1;
    endtask

    task automatic add_row(input logic [7:0] pbyte, input logic typed, input int n,
                           input t_char_result r0, input t_char_result r1);
        t_stim_row row;
        row.pbyte = pbyte;
        row.typed = typed;
        row.n = n[1:0];
        row.r0 = r0;
        row.r1 = r1;
        stim_q.push_back(row);
    endtask

    // Moves whole bytes out of the bit packer into the stimulus queue.
    task automatic flush_packed_bytes();
        logic [7:0] b;
        while (pack_bits.size() >= 8) begin
            for (int k = 7; k >= 0; k--)
                b[k] = pack_bits.pop_front();
            add_row(b, 1'b0, 0, NO_RESULT, NO_RESULT);
        end
    endtask

    // Builds a random string of codes; most end with an end code and padding.
    task automatic add_string();
        int         len;
        int         r;
        logic [4:0] code;
        r = $urandom_range(0, 99);
        len = (r < 80) ? $urandom_range(1, 8) : $urandom_range(9, 40);
        for (int j = 0; j < len; j++) begin
            r = $urandom_range(0, 99);
            if (r < 80)
                code = 5'($urandom_range(1, 29));
            else if (r < 94)
                code = C_CODE_CASE;
            else
                code = C_CODE_NULL;
            for (int k = 4; k >= 0; k--)
                pack_bits.push_back(code[k]);
        end
        // A broken string runs straight into the next one.
        if ($urandom_range(0, 99) < 85) begin
            for (int k = 4; k >= 0; k--)
                pack_bits.push_back(C_CODE_END[k]);
            while (pack_bits.size() % 8 != 0)
                pack_bits.push_back(1'($urandom_range(0, 1)));
        end
        flush_packed_bytes();
    endtask

    // Scripted stream. Rows after a cleared state have typed expectations.
    task automatic load_directed();
        // A lone end code right after reset.
        add_row(8'h00, 1'b1, 1, END_LAST, NO_RESULT);
        // Two case codes, then characters 2 to 7.
        add_row(8'hF7, 1'b0, 0, NO_RESULT, NO_RESULT);
        add_row(8'h84, 1'b0, 0, NO_RESULT, NO_RESULT);
        add_row(8'h32, 1'b0, 0, NO_RESULT, NO_RESULT);
        add_row(8'h14, 1'b0, 0, NO_RESULT, NO_RESULT);
        add_row(8'hC7, 1'b0, 0, NO_RESULT, NO_RESULT);
        // Characters 8 to 15.
        add_row(8'h42, 1'b0, 0, NO_RESULT, NO_RESULT);
        add_row(8'h54, 1'b0, 0, NO_RESULT, NO_RESULT);
        add_row(8'hB6, 1'b0, 0, NO_RESULT, NO_RESULT);
        add_row(8'h35, 1'b0, 0, NO_RESULT, NO_RESULT);
        add_row(8'hCF, 1'b0, 0, NO_RESULT, NO_RESULT);
        // Characters 17 to 24.
        add_row(8'h8C, 1'b0, 0, NO_RESULT, NO_RESULT);
        add_row(8'hA7, 1'b0, 0, NO_RESULT, NO_RESULT);
        add_row(8'h4A, 1'b0, 0, NO_RESULT, NO_RESULT);
        add_row(8'hDA, 1'b0, 0, NO_RESULT, NO_RESULT);
        add_row(8'hF8, 1'b0, 0, NO_RESULT, NO_RESULT);
        // Characters 25 to 29 and 1, a null code and a case code.
        add_row(8'hCE, 1'b0, 0, NO_RESULT, NO_RESULT);
        add_row(8'hB7, 1'b0, 0, NO_RESULT, NO_RESULT);
        add_row(8'hCE, 1'b0, 0, NO_RESULT, NO_RESULT);
        add_row(8'h87, 1'b0, 0, NO_RESULT, NO_RESULT);
        add_row(8'hFE, 1'b0, 0, NO_RESULT, NO_RESULT);
        // A shifted character, then an end code that spans two bytes.
        add_row(8'h10, 1'b0, 0, NO_RESULT, NO_RESULT);
        add_row(8'h00, 1'b0, 0, NO_RESULT, NO_RESULT);
        // All ones from a clear state: a null code and three pending bits.
        add_row(8'hFF, 1'b1, 0, NO_RESULT, NO_RESULT);
        // Those bits finish a character, then the end code is the second result.
        add_row(8'h00, 1'b1, 2, A1_FIRST, END_LAST);
    endtask

    // Input idle gaps: mostly none or short, a few long, with calm stretches.
    function automatic int pick_gap(input int idx);
        int r;
        r = $urandom_range(0, 99);
        if ((idx / 100) % 3 == 1)
            return 0;
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, pending_chars.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Output stall: random short and long stalls, calm windows, one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else if (!hold_done && bytes_accepted >= HOLD_AT) begin
            hold_done = 1'b1;
            i_stall <= 1'b1;
            stall_left = HOLD_CYCLES - 1;
        end else if ((cycle_count / 1000) % 4 == 2 || $urandom_range(0, 99) < 70) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= 1'b1;
            stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                      : $urandom_range(9, 39);
        end
    end

    // Output check: every transfer is matched against the oldest expectation.
    always @(posedge i_clk) begin
        t_char_result got;
        t_char_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_char_code, o_end_of_string, o_last_of_item};
            if (pending_chars.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("cycle %0d: unexpected result char %02h eos %0b last %0b",
                             cycle_count, got.ch, got.eos, got.last);
            end else begin
                want = pending_chars.pop_front();
                if (want.eos)
                    ends_checked++;
                else
                    chars_checked++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"cycle %0d: expected char %02h eos %0b last %0b, ",
                                  "got char %02h eos %0b last %0b"},
                                 cycle_count, want.ch, want.eos, want.last,
                                 got.ch, got.eos, got.last);
                end
            end
        end
    end

    // Reset, stimulus, drain and verdict.
    initial begin
        t_stim_row row;
        int        gap;
        int        n_directed;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_packed_byte <= 8'h00;
        bytes_accepted = 0;
        uppers_predicted = 0;
        dec_accum = '0;
        dec_nbits = '0;
        dec_case = '0;

        load_directed();
        n_directed = stim_q.size();
        while (stim_q.size() < n_directed + RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 10) begin
                repeat ($urandom_range(1, 4))
                    add_row(8'($urandom_range(0, 255)), 1'b0, 0, NO_RESULT, NO_RESULT);
            end else begin
                add_string();
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Offer each byte, then predict its results at the transfer edge.
        while (bytes_accepted < stim_q.size()) begin
            row = stim_q[bytes_accepted];
            gap = pick_gap(bytes_accepted);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_valid <= 1'b1;
            i_packed_byte <= row.pbyte;
            @(posedge i_clk);
            while (o_stall)
                @(posedge i_clk);
            decode_byte(row.pbyte);
            if (row.typed) begin
                if (row.n > 0)
                    pending_chars.push_back(row.r0);
                if (row.n > 1)
                    pending_chars.push_back(row.r1);
            end else begin
                for (int k = 0; k < fresh_n; k++)
                    pending_chars.push_back(fresh_chars[k]);
            end
            bytes_accepted++;
        end
        i_valid <= 1'b0;

        while (pending_chars.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d bytes (%0d scripted), checked %0d characters and %0d end codes",
                 bytes_accepted, n_directed, chars_checked, ends_checked);
        $display("%0d upper-case characters, long output hold-off %s, %0d mismatches",
                 uppers_predicted, hold_done ? "done" : "missed", mismatches);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
